/* rtl/lpht_pkg.sv */
package lpht_pkg;

   localparam int SLOTS     = 64;
   localparam int IDX_W     = $clog2(SLOTS);
   localparam int LEN_W     = $clog2(SLOTS + 1);
   localparam int KEY_W     = 32;
   localparam int VAL_W     = 32;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 3;
   localparam int MARK_W    = 2;
   localparam int LEN_RESET = 53;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

   localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
   localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
   localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

   typedef struct packed {
      logic [MARK_W-1:0] mark;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
   } entry_type;

endpackage

/* rtl/lpht_req_if.sv */
interface lpht_req_if;
   logic                      valid;
   logic                      ready;
   logic [lpht_pkg::OP_W-1:0]  op;
   logic [lpht_pkg::KEY_W-1:0] key;
   logic [lpht_pkg::VAL_W-1:0] value;

   modport source (output valid, output op, output key, output value, input ready);
   modport sink   (input valid, input op, input key, input value, output ready);
endinterface

/* rtl/lpht_rsp_if.sv */
interface lpht_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lpht_pkg::STATUS_W-1:0] status;
   logic [lpht_pkg::VAL_W-1:0]    found_value;
   logic [lpht_pkg::LEN_W-1:0]    live_count;

   modport source (output valid, output status, output found_value, output live_count,
                   input ready);
   modport sink   (input valid, input status, input found_value, input live_count,
                   output ready);
endinterface

/* rtl/linear_probe_hash_table.sv */
// Key/value table with open addressing and linear probing.
// req_chan carries one item (op, key, value); op 0 inserts, 1 removes,
// 2 finds, 3 does nothing. rsp_chan returns one item per request with
// status, found_value and live_count. Both are valid/ready channels.
// csr_write_en/csr_write_data set the table length (slots probed and the
// modulus for the home slot); write it only while the block is idle.
// A length of 0 acts as 1 and one above 64 acts as 64.
// One item at a time. The home slot comes from a bit-serial remainder
// unit, then the walk reads the slot memory one slot a cycle, through a
// registered read, for k slots (1 to table length). A new item is
// accepted only after the last one has committed its result.
// The result sits in an output register; the next item is accepted while
// it waits, and the block holds its commit step while rsp_chan stalls.
// Reset (synchronous) clears every slot to empty through per-slot valid
// bits, zeroes the live count and sets the length to 53. No clearing pass.
module linear_probe_hash_table (
   input  logic                          clock,
   input  logic                          reset,
   lpht_req_if.sink                      req_chan,
   lpht_rsp_if.source                    rsp_chan,
   input  logic                          csr_write_en,
   input  logic [lpht_pkg::LEN_W-1:0]    csr_write_data
);

   localparam int IW = lpht_pkg::IDX_W;
   localparam int LW = lpht_pkg::LEN_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [LW-1:0]              len_ff;
   logic [LW-1:0]              len_eff;
   logic [lpht_pkg::OP_W-1:0]  op_ff;
   logic [lpht_pkg::KEY_W-1:0] key_ff;
   logic [lpht_pkg::VAL_W-1:0] value_ff;

   logic [IW-1:0]              rd_pos_ff, rd_pos_in;
   logic                       rd_issue_ff, rd_issue_in;
   logic [IW-1:0]              chk_pos_ff, chk_pos_in;
   logic [LW-1:0]              probe_cnt_ff, probe_cnt_in;
   logic                       free_vld_ff, free_vld_in;
   logic [IW-1:0]              free_pos_ff, free_pos_in;
   logic                       hit_ff, hit_in;
   logic [IW-1:0]              hit_pos_ff, hit_pos_in;
   logic [lpht_pkg::VAL_W-1:0] hit_value_ff, hit_value_in;
   logic [LW-1:0]              used_ff, used_in;

   lpht_pkg::entry_type        mem [lpht_pkg::SLOTS];
   lpht_pkg::entry_type        rd_entry_ff;
   logic                       rd_vbit_ff;
   logic [lpht_pkg::SLOTS-1:0] slot_vld_ff, slot_vld_in;
   logic                       wr_en;
   logic [IW-1:0]              wr_addr;
   lpht_pkg::entry_type        wr_data;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lpht_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [lpht_pkg::VAL_W-1:0]    fval_ff, fval_in;
   logic [LW-1:0]                 live_ff, live_in;

   logic                       accept;
   logic                       div_start;
   logic                       div_done;
   logic [IW-1:0]              div_rem;
   logic [lpht_pkg::MARK_W-1:0] seen_mark;
   logic                       walk_stop;
   logic [LW-1:0]              pos_inc;
   logic                       commit;

   always_comb begin
      if (len_ff == '0) begin
         len_eff = LW'(1);
      end else if (len_ff > LW'(lpht_pkg::SLOTS)) begin
         len_eff = LW'(lpht_pkg::SLOTS);
      end else begin
         len_eff = len_ff;
      end
   end

   assign accept    = req_chan.valid && req_chan.ready;
   assign div_start = accept && (req_chan.op == lpht_pkg::OP_INSERT ||
                                 req_chan.op == lpht_pkg::OP_REMOVE ||
                                 req_chan.op == lpht_pkg::OP_FIND);
   assign req_chan.ready = (state_ff == S_IDLE);

   lpht_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_chan.key),
      .divisor   (len_eff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign seen_mark = rd_vbit_ff ? rd_entry_ff.mark : lpht_pkg::MARK_EMPTY;
   assign pos_inc   = {1'b0, rd_pos_ff} + 1'b1;
   assign commit    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      rd_pos_in    = rd_pos_ff;
      rd_issue_in  = 1'b0;
      chk_pos_in   = chk_pos_ff;
      probe_cnt_in = probe_cnt_ff;
      free_vld_in  = free_vld_ff;
      free_pos_in  = free_pos_ff;
      hit_in       = hit_ff;
      hit_pos_in   = hit_pos_ff;
      hit_value_in = hit_value_ff;
      walk_stop    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = div_start ? S_DIV : S_DONE;
               hit_in   = 1'b0;
               free_vld_in = 1'b0;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in     = S_WALK;
               rd_pos_in    = div_rem;
               probe_cnt_in = '0;
            end
         end
         S_WALK: begin
            // reads run one slot ahead; a read past the stop is dropped
            if (rd_issue_ff) begin
               probe_cnt_in = probe_cnt_ff + 1'b1;
               if (seen_mark == lpht_pkg::MARK_USED) begin
                  if (rd_entry_ff.key == key_ff) begin
                     hit_in       = 1'b1;
                     hit_pos_in   = chk_pos_ff;
                     hit_value_in = rd_entry_ff.value;
                     walk_stop    = 1'b1;
                  end
               end else begin
                  if (!free_vld_ff) begin
                     free_vld_in = 1'b1;
                     free_pos_in = chk_pos_ff;
                  end
                  if (seen_mark == lpht_pkg::MARK_EMPTY) begin
                     walk_stop = 1'b1;
                  end
               end
               if (probe_cnt_in == len_eff) begin
                  walk_stop = 1'b1;
               end
            end
            if (walk_stop) begin
               state_in = S_DONE;
            end else begin
               rd_issue_in = 1'b1;
               chk_pos_in  = rd_pos_ff;
               rd_pos_in   = (pos_inc >= len_eff) ? '0 : pos_inc[IW-1:0];
            end
         end
         S_DONE: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result and write-back at commit
   always_comb begin
      status_in    = lpht_pkg::ST_MISS;
      fval_in      = '0;
      used_in      = used_ff;
      wr_en        = 1'b0;
      wr_addr      = hit_pos_ff;
      wr_data.mark  = lpht_pkg::MARK_DELETED;
      wr_data.key   = key_ff;
      wr_data.value = hit_value_ff;
      case (op_ff)
         lpht_pkg::OP_INSERT: begin
            if (hit_ff) begin
               status_in = lpht_pkg::ST_PRESENT;
            end else if (free_vld_ff) begin
               status_in     = lpht_pkg::ST_INSERTED;
               wr_en         = commit;
               wr_addr       = free_pos_ff;
               wr_data.mark  = lpht_pkg::MARK_USED;
               wr_data.value = value_ff;
               used_in       = used_ff + 1'b1;
            end else begin
               status_in = lpht_pkg::ST_FULL;
            end
         end
         lpht_pkg::OP_REMOVE: begin
            if (hit_ff) begin
               status_in = lpht_pkg::ST_HIT;
               wr_en     = commit;
               used_in   = used_ff - 1'b1;
            end
         end
         lpht_pkg::OP_FIND: begin
            if (hit_ff) begin
               status_in = lpht_pkg::ST_HIT;
               fval_in   = hit_value_ff;
            end
         end
         default: begin
            status_in = lpht_pkg::ST_MISS;
         end
      endcase
      slot_vld_in = slot_vld_ff;
      if (wr_en) begin
         slot_vld_in[wr_addr] = 1'b1;
      end
      live_in      = used_in;
      rsp_valid_in = commit || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= LW'(lpht_pkg::LEN_RESET);
         used_ff      <= '0;
         slot_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rd_issue_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_en) begin
            len_ff <= csr_write_data;
         end
         if (commit) begin
            used_ff <= used_in;
         end
         slot_vld_ff  <= slot_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_issue_ff  <= rd_issue_in;
      end
      if (accept) begin
         op_ff    <= req_chan.op;
         key_ff   <= req_chan.key;
         value_ff <= req_chan.value;
      end
      rd_pos_ff    <= rd_pos_in;
      chk_pos_ff   <= chk_pos_in;
      probe_cnt_ff <= probe_cnt_in;
      free_vld_ff  <= free_vld_in;
      free_pos_ff  <= free_pos_in;
      hit_ff       <= hit_in;
      hit_pos_ff   <= hit_pos_in;
      hit_value_ff <= hit_value_in;
      if (commit) begin
         status_ff <= status_in;
         fval_ff   <= fval_in;
         live_ff   <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_entry_ff <= mem[rd_pos_ff];
      rd_vbit_ff  <= slot_vld_ff[rd_pos_ff];
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.found_value = fval_ff;
   assign rsp_chan.live_count  = live_ff;

endmodule

/* rtl/lpht_mod.sv */
module lpht_mod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lpht_pkg::KEY_W-1:0] dividend,
   input  logic [lpht_pkg::LEN_W-1:0] divisor,
   output logic                       done,
   output logic [lpht_pkg::IDX_W-1:0] remainder
);

   localparam int CNT_W = $clog2(lpht_pkg::KEY_W);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [lpht_pkg::KEY_W-1:0] dvd_ff, dvd_in;
   logic [lpht_pkg::IDX_W-1:0] rem_ff, rem_in;
   logic [lpht_pkg::LEN_W-1:0] dsr_ff, dsr_in;
   logic [lpht_pkg::LEN_W-1:0] shifted;
   logic [lpht_pkg::LEN_W-1:0] trial;

   // one quotient bit a cycle, remainder only
   always_comb begin
      shifted = {rem_ff, dvd_ff[lpht_pkg::KEY_W-1]};
      trial   = (shifted >= dsr_ff) ? shifted - dsr_ff : shifted;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[lpht_pkg::KEY_W-2:0], 1'b0};
         rem_in = trial[lpht_pkg::IDX_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(lpht_pkg::KEY_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* sim/table_checker.sv */
`timescale 1ns / 100ps

module table_checker (
   input  logic                       clock,
   input  logic                       reset,
   lpht_req_if                        req_mon,
   lpht_rsp_if                        rsp_mon,
   input  logic                       csr_write_en,
   input  logic [lpht_pkg::LEN_W-1:0] csr_write_data,
   output int                         fail_count,
   output int                         pending_count
);

   typedef struct packed {
      logic [lpht_pkg::STATUS_W-1:0] status;
      logic [lpht_pkg::VAL_W-1:0]    found_value;
      logic [lpht_pkg::LEN_W-1:0]    live_count;
   } table_rsp_type;

   logic [lpht_pkg::MARK_W-1:0] slot_state [lpht_pkg::SLOTS];
   logic [lpht_pkg::KEY_W-1:0]  slot_keys  [lpht_pkg::SLOTS];
   logic [lpht_pkg::VAL_W-1:0]  slot_vals  [lpht_pkg::SLOTS];
   logic [lpht_pkg::LEN_W-1:0]  live_slots;
   logic [lpht_pkg::LEN_W-1:0]  length_reg;
   table_rsp_type               expected_rsp [$];

   // Walk the table as the block does and update the shadow copy.
   function automatic table_rsp_type apply_table_op(
      input logic [lpht_pkg::OP_W-1:0]  op,
      input logic [lpht_pkg::KEY_W-1:0] key,
      input logic [lpht_pkg::VAL_W-1:0] value);
      table_rsp_type rsp;
      int            n;
      int            pos;
      int            hit;
      int            free_slot;
      bit            stop;
      n = int'(length_reg);
      if (n == 0) n = 1;
      if (n > lpht_pkg::SLOTS) n = lpht_pkg::SLOTS;
      pos       = int'(key % 32'(n));
      hit       = -1;
      free_slot = -1;
      stop      = 1'b0;
      for (int i = 0; i < n && !stop; i++) begin
         if (slot_state[pos] == lpht_pkg::MARK_USED) begin
            if (slot_keys[pos] == key) begin
               hit  = pos;
               stop = 1'b1;
            end
         end else begin
            if (free_slot < 0) free_slot = pos;
            // an empty slot ends the walk; deleted slots do not
            if (slot_state[pos] == lpht_pkg::MARK_EMPTY) stop = 1'b1;
         end
         pos = (pos + 1 == n) ? 0 : pos + 1;
      end
      rsp.status      = lpht_pkg::ST_MISS;
      rsp.found_value = '0;
      case (op)
         lpht_pkg::OP_INSERT: begin
            if (hit >= 0) begin
               rsp.status = lpht_pkg::ST_PRESENT;
            end else if (free_slot >= 0) begin
               slot_state[free_slot] = lpht_pkg::MARK_USED;
               slot_keys[free_slot]  = key;
               slot_vals[free_slot]  = value;
               live_slots            = live_slots + 1'b1;
               rsp.status            = lpht_pkg::ST_INSERTED;
            end else begin
               rsp.status = lpht_pkg::ST_FULL;
            end
         end
         lpht_pkg::OP_REMOVE: begin
            if (hit >= 0) begin
               slot_state[hit] = lpht_pkg::MARK_DELETED;
               live_slots      = live_slots - 1'b1;
               rsp.status      = lpht_pkg::ST_HIT;
            end
         end
         lpht_pkg::OP_FIND: begin
            if (hit >= 0) begin
               rsp.status      = lpht_pkg::ST_HIT;
               rsp.found_value = slot_vals[hit];
            end
         end
         default: ;
      endcase
      rsp.live_count = live_slots;
      return rsp;
   endfunction

   always @(posedge clock) begin
      table_rsp_type want;
      if (reset) begin
         for (int i = 0; i < lpht_pkg::SLOTS; i++) slot_state[i] = lpht_pkg::MARK_EMPTY;
         live_slots = '0;
         length_reg = (lpht_pkg::LEN_W)'(lpht_pkg::LEN_RESET);
         fail_count = 0;
         expected_rsp.delete();
      end else begin
         if (csr_write_en) length_reg = csr_write_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: result with nothing expected: status %0d value %h count %0d",
                        $time, rsp_mon.status, rsp_mon.found_value, rsp_mon.live_count);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, rsp_mon.status);
                  fail_count++;
               end
               if (rsp_mon.found_value !== want.found_value) begin
                  $display("%0t: found_value expected %h got %h",
                           $time, want.found_value, rsp_mon.found_value);
                  fail_count++;
               end
               if (rsp_mon.live_count !== want.live_count) begin
                  $display("%0t: live_count expected %0d got %0d",
                           $time, want.live_count, rsp_mon.live_count);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_rsp.push_back(apply_table_op(req_mon.op, req_mon.key, req_mon.value));
      end
      pending_count = expected_rsp.size();
   end

endmodule

/* sim/linear_probe_hash_table_test.sv */
`timescale 1ns / 100ps

module linear_probe_hash_table_test;

   localparam logic [lpht_pkg::OP_W-1:0] OP_NONE        = 2'd3;
   localparam int                        WATCHDOG_LIMIT = 4000;
   localparam int                        PHASES         = 12;
   localparam int                        PHASE_ITEMS    = 156;
   localparam int                        POOL_MAX       = 2 * lpht_pkg::SLOTS + 2;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_en;
   logic [lpht_pkg::LEN_W-1:0] csr_write_data;
   int                         fail_count;
   int                         pending_count;
   int                         gap_pct;
   int                         stall_pct;
   int                         quiet_cycles;
   int                         phase_len [PHASES] = '{1, 64, 7, 127, 0, 16, 3, 40, 64, 2,
                                                      53, 31};
   logic [lpht_pkg::KEY_W-1:0] key_pool [POOL_MAX];
   int                         pool_size;

   lpht_req_if req_bus ();
   lpht_rsp_if rsp_bus ();

   linear_probe_hash_table u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   table_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic [lpht_pkg::OP_W-1:0]  op,
                            input logic [lpht_pkg::KEY_W-1:0] key,
                            input logic [lpht_pkg::VAL_W-1:0] value);
      while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.key   <= key;
      req_bus.value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Drop valid and hold until every outstanding item has its result.
   task automatic wait_results_done();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_table_len(input logic [lpht_pkg::LEN_W-1:0] len);
      wait_results_done();
      csr_write_en   <= 1'b1;
      csr_write_data <= len;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Two of every three pool keys are the key before them plus a multiple of the length, so probe chains get long.
   task automatic build_key_pool(input int len);
      int eff;
      eff       = (len == 0) ? 1 : ((len > lpht_pkg::SLOTS) ? lpht_pkg::SLOTS : len);
      pool_size = 2 * eff + 2;
      for (int i = 0; i < pool_size; i++) begin
         if (i % 3 == 0)
            key_pool[i] = $urandom;
         else
            key_pool[i] = key_pool[i-1] +
                          (lpht_pkg::KEY_W)'(eff * $urandom_range(1, 3));
      end
   endtask

   initial begin
      int                         sel;
      logic [lpht_pkg::OP_W-1:0]  op;
      logic [lpht_pkg::KEY_W-1:0] key;
      req_bus.valid  <= 1'b0;
      req_bus.op     <= lpht_pkg::OP_INSERT;
      req_bus.key    <= '0;
      req_bus.value  <= '0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      reset          <= 1'b1;
      gap_pct         = 0;
      stall_pct       = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // default length: presence, deletion and reuse of deleted slots
      send_item(lpht_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_item(lpht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(lpht_pkg::OP_INSERT, 32'h0000_0000, 32'h1234_5678);
      send_item(lpht_pkg::OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
      send_item(lpht_pkg::OP_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
      send_item(lpht_pkg::OP_FIND,   32'd53,        32'h0000_0000);
      send_item(lpht_pkg::OP_INSERT, 32'd53,        32'hA5A5_A5A5);
      send_item(lpht_pkg::OP_INSERT, 32'd106,       32'h5A5A_5A5A);
      send_item(lpht_pkg::OP_REMOVE, 32'd53,        32'h0000_0000);
      send_item(lpht_pkg::OP_FIND,   32'd106,       32'h0000_0000);
      send_item(lpht_pkg::OP_REMOVE, 32'd53,        32'h0000_0000);
      send_item(lpht_pkg::OP_INSERT, 32'd106,       32'h0F0F_0F0F);
      send_item(lpht_pkg::OP_INSERT, 32'd159,       32'hC3C3_C3C3);
      send_item(OP_NONE,             32'h0000_0000, 32'hFFFF_FFFF);
      send_item(lpht_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);

      // one slot: full table, entries beyond the length still counted
      write_table_len((lpht_pkg::LEN_W)'(1));
      send_item(lpht_pkg::OP_INSERT, 32'd5,         32'h0000_0005);
      send_item(lpht_pkg::OP_FIND,   32'h0000_0000, 32'h0000_0000);
      send_item(lpht_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
      send_item(lpht_pkg::OP_INSERT, 32'd7,         32'h0000_0007);

      // zero acts as one
      write_table_len((lpht_pkg::LEN_W)'(0));
      send_item(lpht_pkg::OP_INSERT, 32'd9,         32'h0000_0009);
      send_item(lpht_pkg::OP_FIND,   32'd7,         32'h0000_0000);

      // above the slot count acts as the slot count
      write_table_len((lpht_pkg::LEN_W)'(127));
      send_item(lpht_pkg::OP_INSERT, 32'd64,        32'hFFFF_FFFF);
      send_item(lpht_pkg::OP_FIND,   32'd64,        32'h0000_0000);
      send_item(lpht_pkg::OP_FIND,   32'd159,       32'h0000_0000);

      for (int p = 0; p < PHASES; p++) begin
         write_table_len((lpht_pkg::LEN_W)'(phase_len[p]));
         build_key_pool(phase_len[p]);
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 59; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 59; end
            default: begin gap_pct = 12; stall_pct = 12; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 5 && i == PHASE_ITEMS / 2) wait_results_done();
            sel = $urandom_range(0, 99);
            if (sel < 45)      op = lpht_pkg::OP_INSERT;
            else if (sel < 65) op = lpht_pkg::OP_REMOVE;
            else if (sel < 93) op = lpht_pkg::OP_FIND;
            else               op = OP_NONE;
            if ($urandom_range(0, 9) == 0) key = $urandom;
            else                           key = key_pool[$urandom_range(0, pool_size - 1)];
            send_item(op, key, $urandom);
         end
      end

      wait_results_done();
      repeat (120) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
